/* hdl/pflru_pkg.sv */
// shared types and codes for the page frame lru swap manager
// no dependencies
`timescale 1ns / 1ps

package pflru_pkg;

  typedef enum logic [1:0] {
    FUNC_TRANSLATE = 2'd0,
    FUNC_ACQUIRE   = 2'd1,
    FUNC_RELEASE   = 2'd2,
    FUNC_TOUCH     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOWHERE  = 2'd1,
    ST_SWAPFULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  space_id;
    logic [31:0] vaddr;
    logic [24:0] vpn;
    logic [4:0]  frame;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  frame_out;
    logic [11:0] phys_addr;
    logic        swapped_in;
    logic [9:0]  read_sector;
    logic        evicted;
    logic [7:0]  victim_space;
    logic [24:0] victim_vpn;
    logic [9:0]  write_sector;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_FSCAN,
    S_FLAST,
    S_FDEC,
    S_SSCAN,
    S_SLAST,
    S_SDEC,
    S_TAKE,
    S_VREAD,
    S_VTAG,
    S_VWRITE,
    S_LSCAN,
    S_LEND,
    S_SWAPIN,
    S_DONE
  } state_t;

endpackage

/* hdl/page_frame_lru_swap_manager.sv */
// top level: frame table, sector table and lru list, each in its own synchronous memory
// depends on pflru_pkg
`timescale 1ns / 1ps
//
//  channel | signals                    | handshake
//  cmd     | start, busy, cmd (cmd_t)   | word taken at an edge with start high, busy low
//  rsp     | done, rsp (rsp_t)          | one cycle strobe, the receiver cannot stall
//
//  after reset a clearing pass zeroes the sector memory with busy high
//  one word at a time: busy is high from the accepting edge until the done cycle
//  the longest word, a translate miss with swap-in and eviction, is set by the
//  one-entry-per-cycle scans of the frame, sector and lru memories
//  an acquire into a free frame goes straight from the take state to the done state
//  PAGE_BYTES is to be a power of two; the block itself does not enforce it

module page_frame_lru_swap_manager #(
  parameter int FRAMES     = 32,
  parameter int SECTORS    = 1024,
  parameter int PAGE_BYTES = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  pflru_pkg::cmd_t cmd,
  output logic            done,
  output pflru_pkg::rsp_t rsp
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int SW = (SECTORS > 1) ? $clog2(SECTORS) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int OW = $clog2(PAGE_BYTES);
  localparam int IW = ((SW > FW) ? SW : FW) + 1;

  // memories
  logic [32:0] ftag_mem [FRAMES];
  logic [33:0] stag_mem [SECTORS];   // used bit, space, page
  logic [FW-1:0] lru_mem [FRAMES];
  logic [FRAMES-1:0] fused;
  logic [CW-1:0] lcnt;

  logic [32:0] ftag_q;
  logic [33:0] stag_q;
  logic [FW-1:0] lru_q;

  logic [FW-1:0] f_ra, l_ra;
  logic [SW-1:0] s_ra;
  logic f_we, s_we, l_we;
  logic [FW-1:0] f_wa, l_wa;
  logic [SW-1:0] s_wa;
  logic [32:0] f_wd;
  logic [33:0] s_wd;
  logic [FW-1:0] l_wd;

  always_ff @(posedge clk) begin
    if (f_we) ftag_mem[f_wa] <= f_wd;
    ftag_q <= ftag_mem[f_ra];
  end
  always_ff @(posedge clk) begin
    if (s_we) stag_mem[s_wa] <= s_wd;
    stag_q <= stag_mem[s_ra];
  end
  always_ff @(posedge clk) begin
    if (l_we) lru_mem[l_wa] <= l_wd;
    lru_q <= lru_mem[l_ra];
  end

  pflru_pkg::state_t state, state_next;
  pflru_pkg::func_t c_func;
  logic [7:0] sp;
  logic [24:0] pg;
  logic [OW-1:0] off;
  logic [IW-1:0] ix;     // scan index
  logic fpv, spv, lpv;   // read data of the scan is on the memory output
  logic [FW-1:0] fpix;
  logic [SW-1:0] spix;
  logic hit_v; logic [FW-1:0] hit_f;
  logic sec_v; logic [SW-1:0] sec_s;
  logic free_v; logic [SW-1:0] free_s;
  logic [FW-1:0] mover;  // frame to move to the tail
  logic mv_v;
  logic [FW-1:0] victim;
  logic [CW-1:0] wp;     // lru compaction write position
  pflru_pkg::rsp_t r;

  logic rel, trn;
  assign rel = (c_func == pflru_pkg::FUNC_RELEASE);
  assign trn = (c_func == pflru_pkg::FUNC_TRANSLATE);

  // first free frame, priority over flip-flop bits
  logic ff_v; logic [FW-1:0] ff_f;
  always_comb begin
    ff_v = 1'b0; ff_f = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (!fused[k]) begin ff_v = 1'b1; ff_f = FW'(k); end
    end
  end

  logic fmatch, smatch, keep, touch_ok;
  assign fmatch = fused[fpix] && ftag_q == {sp, pg};
  assign smatch = stag_q[33] && stag_q[32:0] == {sp, pg};
  assign keep = fused[lru_q] && !(mv_v && lru_q == mover);
  assign touch_ok = (int'(cmd.frame) < FRAMES) && fused[FW'(cmd.frame)];

  function automatic logic [11:0] phys_of(input logic [FW-1:0] f);
    return 12'((32'(f) << OW) | 32'(off));
  endfunction

  assign busy = (state != pflru_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= pflru_pkg::S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    f_ra = ix[FW-1:0]; s_ra = ix[SW-1:0]; l_ra = ix[FW-1:0];
    f_we = 1'b0; f_wa = victim; f_wd = {sp, pg};
    s_we = 1'b0; s_wa = spix; s_wd = '0;
    l_we = 1'b0; l_wa = FW'(wp); l_wd = lru_q;
    case (state)
      pflru_pkg::S_CLEAR: begin
        s_we = 1'b1; s_wa = ix[SW-1:0];
        if (ix == IW'(SECTORS - 1)) state_next = pflru_pkg::S_IDLE;
      end
      pflru_pkg::S_IDLE: if (start) begin
        case (pflru_pkg::func_t'(cmd.func))
          pflru_pkg::FUNC_TRANSLATE: state_next = pflru_pkg::S_FSCAN;
          pflru_pkg::FUNC_RELEASE:   state_next = pflru_pkg::S_FSCAN;
          pflru_pkg::FUNC_ACQUIRE:
            state_next = ff_v ? pflru_pkg::S_TAKE : pflru_pkg::S_SSCAN;
          pflru_pkg::FUNC_TOUCH:
            state_next = touch_ok ? pflru_pkg::S_LSCAN : pflru_pkg::S_DONE;
          default:                   state_next = pflru_pkg::S_DONE;
        endcase
      end
      pflru_pkg::S_FSCAN: if (ix == IW'(FRAMES - 1)) state_next = pflru_pkg::S_FLAST;
      pflru_pkg::S_FLAST: state_next = pflru_pkg::S_FDEC;
      pflru_pkg::S_FDEC:
        state_next = (!rel && hit_v) ? pflru_pkg::S_DONE : pflru_pkg::S_SSCAN;
      pflru_pkg::S_SSCAN: begin
        if (spv && rel && smatch) s_we = 1'b1;
        if (ix == IW'(SECTORS - 1)) state_next = pflru_pkg::S_SLAST;
      end
      pflru_pkg::S_SLAST: begin
        if (spv && rel && smatch) s_we = 1'b1;
        state_next = pflru_pkg::S_SDEC;
      end
      pflru_pkg::S_SDEC: begin
        if (rel) state_next = pflru_pkg::S_LSCAN;
        else if (trn && !sec_v) state_next = pflru_pkg::S_DONE;
        else if (ff_v) state_next = pflru_pkg::S_TAKE;
        else if (!free_v || lcnt == '0) state_next = pflru_pkg::S_DONE;
        else state_next = pflru_pkg::S_VREAD;
      end
      pflru_pkg::S_TAKE: begin
        f_we = 1'b1; f_wa = ff_f;
        l_we = 1'b1; l_wa = FW'(lcnt); l_wd = ff_f;
        state_next = trn ? pflru_pkg::S_SWAPIN : pflru_pkg::S_DONE;
      end
      pflru_pkg::S_VREAD: begin
        l_ra = '0;
        state_next = pflru_pkg::S_VTAG;
      end
      pflru_pkg::S_VTAG: begin
        f_ra = lru_q;
        state_next = pflru_pkg::S_VWRITE;
      end
      pflru_pkg::S_VWRITE: begin
        s_we = 1'b1; s_wa = free_s; s_wd = {1'b1, ftag_q};
        f_we = 1'b1; f_wa = victim;
        state_next = pflru_pkg::S_LSCAN;
      end
      pflru_pkg::S_LSCAN: begin
        if (lpv && keep) l_we = 1'b1;
        if (ix >= IW'(lcnt)) state_next = pflru_pkg::S_LEND;
      end
      pflru_pkg::S_LEND: begin
        if (mv_v) begin l_we = 1'b1; l_wd = mover; end
        state_next = trn ? pflru_pkg::S_SWAPIN : pflru_pkg::S_DONE;
      end
      pflru_pkg::S_SWAPIN: begin
        s_we = 1'b1; s_wa = sec_s; s_wd = '0;
        state_next = pflru_pkg::S_DONE;
      end
      pflru_pkg::S_DONE: state_next = pflru_pkg::S_IDLE;
      default: state_next = pflru_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ix <= '0;
      fused <= '0; lcnt <= '0;
      fpv <= 1'b0; spv <= 1'b0; lpv <= 1'b0;
      done <= 1'b0; rsp <= '0;
    end else begin
      done <= (state == pflru_pkg::S_DONE);
      if (state == pflru_pkg::S_DONE) rsp <= r;
      case (state)
        pflru_pkg::S_CLEAR: ix <= ix + 1'b1;
        pflru_pkg::S_IDLE: begin
          ix <= '0; wp <= '0;
          c_func <= pflru_pkg::func_t'(cmd.func);
          sp <= cmd.space_id;
          pg <= (cmd.func == pflru_pkg::FUNC_TRANSLATE) ? 25'(cmd.vaddr >> OW) : cmd.vpn;
          off <= cmd.vaddr[OW-1:0];
          hit_v <= 1'b0; sec_v <= 1'b0; free_v <= 1'b0;
          mover <= FW'(cmd.frame);
          mv_v <= (cmd.func == pflru_pkg::FUNC_TOUCH);
          r <= '0;
        end
        pflru_pkg::S_FSCAN: begin
          ix <= ix + 1'b1; fpix <= ix[FW-1:0]; fpv <= 1'b1;
          if (fpv && fmatch) begin
            hit_v <= 1'b1; hit_f <= fpix;
            if (rel) fused[fpix] <= 1'b0;
          end
        end
        pflru_pkg::S_FLAST: begin
          fpv <= 1'b0;
          if (fpv && fmatch) begin
            hit_v <= 1'b1; hit_f <= fpix;
            if (rel) fused[fpix] <= 1'b0;
          end
        end
        pflru_pkg::S_FDEC: begin
          ix <= '0;
          if (!rel && hit_v) begin
            r.frame_out <= 5'(hit_f);
            r.phys_addr <= phys_of(hit_f);
          end
        end
        pflru_pkg::S_SSCAN: begin
          ix <= ix + 1'b1; spix <= ix[SW-1:0]; spv <= 1'b1;
          if (spv && smatch && !sec_v) begin sec_v <= 1'b1; sec_s <= spix; end
          if (spv && !stag_q[33] && !free_v) begin free_v <= 1'b1; free_s <= spix; end
        end
        pflru_pkg::S_SLAST: begin
          spv <= 1'b0;
          if (spv && smatch && !sec_v) begin sec_v <= 1'b1; sec_s <= spix; end
          if (spv && !stag_q[33] && !free_v) begin free_v <= 1'b1; free_s <= spix; end
        end
        pflru_pkg::S_SDEC: begin
          ix <= '0; wp <= '0;
          if (trn && !sec_v) r.status <= pflru_pkg::ST_NOWHERE;
          else if (!rel && !ff_v && (!free_v || lcnt == '0)) r.status <= pflru_pkg::ST_SWAPFULL;
        end
        pflru_pkg::S_TAKE: begin
          fused[ff_f] <= 1'b1;
          lcnt <= lcnt + 1'b1;
          r.frame_out <= 5'(ff_f);
          if (trn) begin
            r.phys_addr <= phys_of(ff_f);
            r.swapped_in <= 1'b1;
            r.read_sector <= 10'(sec_s);
          end
        end
        pflru_pkg::S_VTAG: victim <= lru_q;
        pflru_pkg::S_VWRITE: begin
          ix <= '0; wp <= '0;
          mover <= victim; mv_v <= 1'b1;
          r.frame_out <= 5'(victim);
          r.evicted <= 1'b1;
          r.victim_space <= ftag_q[32:25];
          r.victim_vpn <= ftag_q[24:0];
          r.write_sector <= 10'(free_s);
          if (trn) begin
            r.phys_addr <= phys_of(victim);
            r.swapped_in <= 1'b1;
            r.read_sector <= 10'(sec_s);
          end
        end
        pflru_pkg::S_LSCAN: begin
          ix <= ix + 1'b1;
          lpv <= (ix < IW'(lcnt));
          if (lpv && keep) wp <= wp + 1'b1;
        end
        pflru_pkg::S_LEND: lcnt <= mv_v ? wp + 1'b1 : wp;
        default: ;
      endcase
    end
  end

endmodule

/* tb/sv/pflru_checker.sv */
// checker for the page frame lru swap manager: predicts every response word
// from the accepted commands and compares it with the response channel
// depends on pflru_pkg
`timescale 1ns / 1ps

module pflru_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  pflru_pkg::cmd_t cmd,
  input  logic            done,
  input  pflru_pkg::rsp_t rsp,
  output int              fails,
  output int              pending
);

  localparam int NFRAMES  = 32;
  localparam int NSECTORS = 1024;

  logic        fr_used [NFRAMES];
  logic [7:0]  fr_space[NFRAMES];
  logic [24:0] fr_page [NFRAMES];
  logic        sec_used [NSECTORS];
  logic [7:0]  sec_space[NSECTORS];
  logic [24:0] sec_page [NSECTORS];
  int          recency[$];
  pflru_pkg::rsp_t expected_rsp[$];

  initial begin
    fails = 0;
    foreach (fr_used[i]) fr_used[i] = 1'b0;
    foreach (sec_used[i]) sec_used[i] = 1'b0;
  end

  assign pending = expected_rsp.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  task automatic drop_recent(input int f);
    foreach (recency[i]) begin
      if (recency[i] == f) begin
        recency.delete(i);
        return;
      end
    end
  endtask

  // lowest free frame, else evict the oldest frame to the lowest free sector
  task automatic take_frame(input logic [7:0] sp, input logic [24:0] pg,
                            inout pflru_pkg::rsp_t r, output int f);
    int s;
    s = -1;
    for (int i = 0; i < NFRAMES; i++) begin
      if (!fr_used[i]) begin
        fr_used[i] = 1'b1;
        fr_space[i] = sp;
        fr_page[i] = pg;
        if (recency.size() < NFRAMES) recency.push_back(i);
        f = i;
        return;
      end
    end
    for (int i = 0; i < NSECTORS; i++) begin
      if (!sec_used[i]) begin
        s = i;
        break;
      end
    end
    if (s < 0 || recency.size() == 0) begin
      f = -1;
      return;
    end
    f = recency.pop_front();
    sec_used[s] = 1'b1;
    sec_space[s] = fr_space[f];
    sec_page[s] = fr_page[f];
    r.evicted = 1'b1;
    r.victim_space = fr_space[f];
    r.victim_vpn = fr_page[f];
    r.write_sector = s[9:0];
    fr_space[f] = sp;
    fr_page[f] = pg;
    recency.push_back(f);
  endtask

  task automatic predict_rsp(input pflru_pkg::cmd_t c, output pflru_pkg::rsp_t r);
    logic [24:0] tpg;
    logic [6:0]  off;
    int hit, sec, f;
    r = '0;
    r.status = pflru_pkg::ST_OK;
    case (pflru_pkg::func_t'(c.func))
      pflru_pkg::FUNC_TRANSLATE: begin
        tpg = c.vaddr[31:7];
        off = c.vaddr[6:0];
        hit = -1;
        sec = -1;
        for (int i = 0; i < NFRAMES; i++)
          if (fr_used[i] && fr_space[i] == c.space_id && fr_page[i] == tpg) hit = i;
        if (hit < 0) begin
          for (int i = 0; i < NSECTORS; i++) begin
            if (sec_used[i] && sec_space[i] == c.space_id && sec_page[i] == tpg) begin
              sec = i;
              break;
            end
          end
          if (sec < 0) begin
            r.status = pflru_pkg::ST_NOWHERE;
            return;
          end
          take_frame(c.space_id, tpg, r, f);
          if (f < 0) begin
            r = '0;
            r.status = pflru_pkg::ST_SWAPFULL;
            return;
          end
          sec_used[sec] = 1'b0;
          r.swapped_in = 1'b1;
          r.read_sector = sec[9:0];
          hit = f;
        end
        r.frame_out = hit[4:0];
        r.phys_addr = 12'(hit * 128 + int'(off));
      end
      pflru_pkg::FUNC_ACQUIRE: begin
        take_frame(c.space_id, c.vpn, r, f);
        if (f < 0) begin
          r = '0;
          r.status = pflru_pkg::ST_SWAPFULL;
        end else begin
          r.frame_out = f[4:0];
        end
      end
      pflru_pkg::FUNC_RELEASE: begin
        for (int i = 0; i < NFRAMES; i++) begin
          if (fr_used[i] && fr_space[i] == c.space_id && fr_page[i] == c.vpn) begin
            fr_used[i] = 1'b0;
            drop_recent(i);
          end
        end
        for (int i = 0; i < NSECTORS; i++)
          if (sec_used[i] && sec_space[i] == c.space_id && sec_page[i] == c.vpn)
            sec_used[i] = 1'b0;
      end
      default: begin
        if (fr_used[c.frame]) begin
          drop_recent(int'(c.frame));
          recency.push_back(int'(c.frame));
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    pflru_pkg::rsp_t want;
    if (!rst) begin
      if (done) begin
        if (expected_rsp.size() == 0) begin
          report("unexpected word", 32'(rsp), 32'h0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.frame_out != want.frame_out)
            report("frame_out", 32'(rsp.frame_out), 32'(want.frame_out));
          if (rsp.phys_addr != want.phys_addr)
            report("phys_addr", 32'(rsp.phys_addr), 32'(want.phys_addr));
          if (rsp.swapped_in != want.swapped_in)
            report("swapped_in", 32'(rsp.swapped_in), 32'(want.swapped_in));
          if (rsp.read_sector != want.read_sector)
            report("read_sector", 32'(rsp.read_sector), 32'(want.read_sector));
          if (rsp.evicted != want.evicted)
            report("evicted", 32'(rsp.evicted), 32'(want.evicted));
          if (rsp.victim_space != want.victim_space)
            report("victim_space", 32'(rsp.victim_space), 32'(want.victim_space));
          if (rsp.victim_vpn != want.victim_vpn)
            report("victim_vpn", 32'(rsp.victim_vpn), 32'(want.victim_vpn));
          if (rsp.write_sector != want.write_sector)
            report("write_sector", 32'(rsp.write_sector), 32'(want.write_sector));
          if (rsp.status != want.status)
            report("status", 32'(rsp.status), 32'(want.status));
        end
      end
      if (start && !busy) begin
        predict_rsp(cmd, want);
        expected_rsp.push_back(want);
      end
    end
  end
endmodule

/* tb/sv/tb_page_frame_lru_swap_manager.sv */
// testbench top for the page frame lru swap manager: directed and random commands
// and the verdict; depends on pflru_pkg and pflru_checker
`timescale 1ns / 1ps

module tb_page_frame_lru_swap_manager;

  localparam longint LIMIT = 40_000_000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  pflru_pkg::cmd_t cmd;
  logic done;
  pflru_pkg::rsp_t rsp;
  int   fails;
  int   pending;
  longint cycles;

  page_frame_lru_swap_manager dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done), .rsp(rsp)
  );

  pflru_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done), .rsp(rsp),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("page_frame_lru_swap_manager test failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // word is taken at the first edge with start high and busy low
  task automatic send(input pflru_pkg::func_t fn, input logic [7:0] sp,
                      input logic [31:0] va, input logic [24:0] pg,
                      input logic [4:0] fr, input int gap);
    start <= 1'b1;
    cmd <= '{func: fn, space_id: sp, vaddr: va, vpn: pg, frame: fr};
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] rand_space();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 3));
  endfunction

  function automatic logic [24:0] rand_page();
    if ($urandom_range(0, 9) == 0) return 25'($urandom);
    return 25'($urandom_range(0, 15));
  endfunction

  initial begin
    pflru_pkg::func_t fn;
    logic [24:0] vp;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send(pflru_pkg::FUNC_TRANSLATE, 8'hff, 32'hffff_ffff, '0, '0, 0);
    send(pflru_pkg::FUNC_ACQUIRE, 8'h00, 32'h0, 25'h0, 5'd0, 1);
    send(pflru_pkg::FUNC_ACQUIRE, 8'hff, 32'hffff_ffff, 25'h1ff_ffff, 5'd31, 0);
    send(pflru_pkg::FUNC_TRANSLATE, 8'hff, 32'hffff_ffff, 25'h0, 5'd0, 2);
    send(pflru_pkg::FUNC_TRANSLATE, 8'h00, 32'h0000_007f, 25'h0, 5'd0, 0);
    send(pflru_pkg::FUNC_ACQUIRE, 8'h00, 32'h0, 25'h0, 5'd0, 0);
    send(pflru_pkg::FUNC_TRANSLATE, 8'h00, 32'h0000_0041, 25'h0, 5'd0, 0);
    send(pflru_pkg::FUNC_TOUCH, 8'h00, 32'h0, 25'h0, 5'd0, 0);
    send(pflru_pkg::FUNC_TOUCH, 8'hff, 32'hffff_ffff, 25'h1ff_ffff, 5'd31, 3);
    send(pflru_pkg::FUNC_RELEASE, 8'h00, 32'h0, 25'h0, 5'd0, 0);
    send(pflru_pkg::FUNC_RELEASE, 8'h5a, 32'h0, 25'h0aa_aaaa, 5'd0, 0);
    send(pflru_pkg::FUNC_TRANSLATE, 8'h00, 32'h0, 25'h0, 5'd0, 0);
    send(pflru_pkg::FUNC_RELEASE, 8'hff, 32'h0, 25'h1ff_ffff, 5'd0, 5);

    // small page pool larger than the frame count so evictions and swap-ins happen
    for (int n = 0; n < 520; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: fn = pflru_pkg::FUNC_TRANSLATE;
        4, 5, 6:    fn = pflru_pkg::FUNC_ACQUIRE;
        7:          fn = pflru_pkg::FUNC_RELEASE;
        default:    fn = pflru_pkg::FUNC_TOUCH;
      endcase
      vp = rand_page();
      send(fn, rand_space(), {vp, 7'($urandom)}, rand_page(),
           5'($urandom), (n % 100 < 20) ? 0 : pick_gap());
    end

    send(pflru_pkg::FUNC_TRANSLATE, 8'h98, 32'h1234_5678, 25'h0, 5'd0, 0);
    send(pflru_pkg::FUNC_TOUCH, 8'h0, 32'h0, 25'h0, 5'd3, 1);

    while (pending != 0) @(posedge clk);
    repeat (2500) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("page_frame_lru_swap_manager test passed");
    end else begin
      $display("page_frame_lru_swap_manager test failed");
    end
    $finish;
  end
endmodule

/* files.f */
hdl/pflru_pkg.sv
hdl/page_frame_lru_swap_manager.sv
tb/sv/pflru_checker.sv
tb/sv/tb_page_frame_lru_swap_manager.sv
